/* sv/dsdeq_pkg.sv */
// ----------------------------------------------------------------------------
// dsdeq_pkg
// Shared types and constants for the dual switch debouncer with event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dsdeq_pkg;

  // Field and register widths
  localparam int TIME_W     = 32;
  localparam int PERIOD_W   = 16;
  localparam int TICKS_W    = 4;
  localparam int NUM_SW     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int EVT_W      = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 2'd1;

  // Register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd10;
  localparam logic [TICKS_W-1:0]  TICKS_RST  = 4'd3;

  // Request modes
  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_POP  = 2'd2;

  // Queue sizes
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int CMD_DEPTH       = 2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TIME_W-1:0] now_ms;
    logic              button_level;
    logic              sw2_level;
  } req_t;

  typedef struct packed {
    logic event_valid;
    logic event_source;
    logic event_level;
    logic event_pressed;
  } evt_t;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } cmd_op_t;

  // Command passed from the debounce front end to the event queue
  typedef struct packed {
    cmd_op_t           op;
    logic [NUM_SW-1:0] push_valid;
    logic [NUM_SW-1:0] push_level;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/dual_switch_debouncer_event_queue_top.sv */
// ----------------------------------------------------------------------------
// dual_switch_debouncer_event_queue_top
// Debounces a button and a second switch and queues their change events.
//
//   Channel | Direction | Handshake         | Payload
//   --------+-----------+-------------------+-----------------------------
//   req     | in        | req_valid/stall   | mode, now_ms, levels
//   evt     | out       | evt_valid/stall   | event valid/source/level/pressed
//   cfg     | in        | cfg_we            | cfg_index, cfg_data
//
// One request is taken per cycle while req_stall is low. A pop result passes
// through the command queue and comes out of the event store's read
// register. A tick that moves both switches at once writes its two events
// in turn in the event queue (one store write port).
// Reset empties the queue and restores the default configuration; there is no
// clearing pass. evt_stall holds the result and backs up through the
// two-entry command queue to req_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_switch_debouncer_event_queue_top import dsdeq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire req_t                  req,
  output logic                       evt_valid,
  input  wire logic                  evt_stall,
  output evt_t                       evt
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_full;
  logic head_valid;
  cmd_t head;
  logic head_pop;

  dsdeq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_full  (cmd_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  dsdeq_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_valid),
    .push_cmd   (cmd),
    .full       (cmd_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dsdeq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .evt        (evt)
  );

endmodule

`default_nettype wire

/* sv/dsdeq_ram.sv */
// ----------------------------------------------------------------------------
// dsdeq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dsdeq_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/dsdeq_front.sv */
// ----------------------------------------------------------------------------
// dsdeq_front
// Accepts requests, keeps the per-switch debounce state and the sample time,
// and turns each request into a queue command (init, push, pop).
// ----------------------------------------------------------------------------
`default_nettype none

module dsdeq_front import dsdeq_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire req_t                  req,
  input  wire logic                  cmd_full,
  output logic                       cmd_valid,
  output cmd_t                       cmd
);

  logic [PERIOD_W-1:0]             sample_period;
  logic [TICKS_W-1:0]              debounce_ticks;
  logic [TIME_W-1:0]               last_sample_time;
  logic [NUM_SW-1:0]               stable;
  logic [NUM_SW-1:0]               cand;
  logic [NUM_SW-1:0][TICKS_W-1:0]  cnt;

  logic [NUM_SW-1:0]               stable_next;
  logic [NUM_SW-1:0]               cand_next;
  logic [NUM_SW-1:0][TICKS_W-1:0]  cnt_next;
  logic [NUM_SW-1:0]               push_v;
  logic [NUM_SW-1:0]               raw;
  logic [TIME_W-1:0]               elapsed;
  logic                            due;
  logic                            accept;
  logic                            is_init;
  logic                            is_tick;

  assign req_stall = cmd_full;
  assign accept    = req_valid && !cmd_full;
  assign raw       = {req.sw2_level, req.button_level};
  assign is_init   = (req.mode == MODE_INIT);
  assign is_tick   = (req.mode == MODE_TICK);

  // Sample only once the wrapped elapsed time reaches the period
  assign elapsed = req.now_ms - last_sample_time;
  assign due     = (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, sample_period});

  // Per-switch debounce step, button first, second switch after it
  always_comb begin
    logic [TICKS_W-1:0] inc;
    for (int i = 0; i < NUM_SW; i++) begin
      stable_next[i] = stable[i];
      cand_next[i]   = cand[i];
      cnt_next[i]    = cnt[i];
      push_v[i]      = 1'b0;
      inc            = cnt[i];
      if (raw[i] != cand[i]) begin
        // restart the run on a level change
        cand_next[i] = raw[i];
        cnt_next[i]  = TICKS_W'(1);
      end else begin
        if (cnt[i] < debounce_ticks) begin
          inc = cnt[i] + TICKS_W'(1);
        end
        cnt_next[i] = inc;
        if (inc >= debounce_ticks && stable[i] != cand[i]) begin
          stable_next[i] = cand[i];
          push_v[i]      = 1'b1;
        end
      end
    end
  end

  // Build the queue command
  always_comb begin
    cmd_valid       = 1'b0;
    cmd.op          = OP_INIT;
    cmd.push_valid  = '0;
    cmd.push_level  = cand;
    case (req.mode)
      MODE_INIT: begin
        cmd_valid = accept;
        cmd.op    = OP_INIT;
      end
      MODE_TICK: begin
        cmd_valid      = accept && due && (|push_v);
        cmd.op         = OP_PUSH;
        cmd.push_valid = push_v;
      end
      MODE_POP: begin
        cmd_valid = accept;
        cmd.op    = OP_POP;
      end
      default: begin
        cmd_valid = 1'b0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period  <= PERIOD_RST;
      debounce_ticks <= TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_PERIOD: sample_period  <= cfg_data[PERIOD_W-1:0];
        CFG_DEBOUNCE:      debounce_ticks <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Debounce state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time <= '0;
      stable           <= '1;
      cand             <= '1;
      cnt              <= '0;
    end else if (accept) begin
      if (is_init) begin
        last_sample_time <= req.now_ms;
        stable           <= raw;
        cand             <= raw;
        cnt              <= '0;
      end else if (is_tick && due) begin
        last_sample_time <= req.now_ms;
        stable           <= stable_next;
        cand             <= cand_next;
        cnt              <= cnt_next;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/dsdeq_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// dsdeq_cmd_fifo
// Short command queue between the debounce front end and the event queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dsdeq_cmd_fifo import dsdeq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head
);

  localparam int CP_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CC_W = $clog2(CMD_DEPTH + 1);

  cmd_t            entries [CMD_DEPTH];
  logic [CP_W-1:0] wr_ptr;
  logic [CP_W-1:0] rd_ptr;
  logic [CC_W-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CC_W'(CMD_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CP_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + CP_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CP_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + CP_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CC_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/dsdeq_back.sv */
// ----------------------------------------------------------------------------
// dsdeq_back
// Carries out queue commands on the event store: clear, push (one or two
// events, dropped when full) and pop into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsdeq_back import dsdeq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  wire cmd_t head,
  output logic      head_pop,
  output logic      evt_valid,
  input  wire logic evt_stall,
  output evt_t      evt
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  logic [QCNT_W-1:0] count;
  logic              first_done;
  logic              res_empty;

  logic              sel_second;
  logic              push_last;
  logic [EVT_W-1:0]  push_data;
  logic              q_full;
  logic              q_empty;
  logic              do_init;
  logic              do_push;
  logic              do_pop;
  logic              wr_en;
  logic              rd_en;
  logic [EVT_W-1:0]  rdata;

  assign q_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (count == '0);

  // Pick the switch whose event goes in this cycle, button first
  assign sel_second = first_done || !head.push_valid[0];
  assign push_last  = sel_second || !head.push_valid[1];
  assign push_data  = sel_second ? {1'b1, head.push_level[1]}
                                 : {1'b0, head.push_level[0]};

  // Decode the head command
  always_comb begin
    do_init  = 1'b0;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    head_pop = 1'b0;
    if (head_valid) begin
      case (head.op)
        OP_INIT: begin
          do_init  = 1'b1;
          head_pop = 1'b1;
        end
        OP_PUSH: begin
          do_push  = 1'b1;
          head_pop = push_last;
        end
        OP_POP: begin
          do_pop   = !evt_valid || !evt_stall;
          head_pop = do_pop;
        end
        default: begin
          head_pop = 1'b1;
        end
      endcase
    end
  end

  assign wr_en = do_push && !q_full;
  assign rd_en = do_pop && !q_empty;

  dsdeq_ram #(
    .WIDTH (EVT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_ptr),
    .wdata (push_data),
    .re    (rd_en),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  // Pointers, occupancy and push sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      count      <= '0;
      first_done <= 1'b0;
      evt_valid  <= 1'b0;
    end else begin
      if (do_init) begin
        rd_ptr <= '0;
        wr_ptr <= '0;
        count  <= '0;
      end else if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
        count  <= count + QCNT_W'(1);
      end else if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
        count  <= count - QCNT_W'(1);
      end
      if (do_push) begin
        first_done <= !push_last;
      end
      // Output register: load on pop, drop on transfer
      if (do_pop) begin
        evt_valid <= 1'b1;
      end else if (!evt_stall) begin
        evt_valid <= 1'b0;
      end
    end
  end

  // Empty-queue marker for the result held in the read register
  always_ff @(posedge clk) begin
    if (do_pop) begin
      res_empty <= q_empty;
    end
  end

  assign evt.event_valid   = !res_empty;
  assign evt.event_source  = !res_empty && rdata[1];
  assign evt.event_level   = !res_empty && rdata[0];
  assign evt.event_pressed = !res_empty && !rdata[0];

endmodule

`default_nettype wire

/* sv/dsdeq_checker.sv */
// ----------------------------------------------------------------------------
// dsdeq_checker
// Port-level checks on the debouncer top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module dsdeq_checker import dsdeq_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  req_stall,
  input wire logic                  evt_valid,
  input wire logic                  evt_stall,
  input wire evt_t                  evt
);

  // A stalled result stays offered
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_stall |=> evt_valid)
    else $error("result dropped while stalled");

  // Nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !evt_valid && !req_stall)
    else $error("output or stall active after reset");

  // A popped event reports pressed exactly when its level is low
  a_pressed: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt.event_valid |-> evt.event_pressed == !evt.event_level)
    else $error("pressed flag does not match level");

  // An empty-queue result carries all zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt.event_valid |->
      !evt.event_source && !evt.event_level && !evt.event_pressed)
    else $error("empty pop with nonzero fields");

  // A stalled result keeps its payload
  a_evt_stable: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_stall |=> $stable(evt))
    else $error("result payload changed while stalled");

endmodule

bind dual_switch_debouncer_event_queue_top dsdeq_checker u_dsdeq_checker (.*);

`default_nettype wire

/* dv/dual_switch_debouncer_event_queue_top_tb.sv */
// ----------------------------------------------------------------------------
// dual_switch_debouncer_event_queue_top_tb
// Self-checking bench for the two-switch debouncer and its event queue.
// A scoreboard object tracks the debounce state and the event FIFO for every
// request transfer and holds the pop results still to come. Each result
// transfer is compared field by field with the oldest of them. A directed
// opening covers the time wrap, the empty pop, the full queue, the unused
// mode and the zero period and zero debounce settings. Random phases follow,
// each under its own register setting. The sender works in bursts and the
// receiver stalls on its own pattern, with one long hold-off per phase.
// ----------------------------------------------------------------------------

module dual_switch_debouncer_event_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsdeq_pkg::*;

  localparam int QDEPTH         = QUEUE_DEPTH_DEF;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 260;

  // Mode and register codes that the package leaves unnamed
  localparam logic [1:0]           MODE_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  // Debounce state, event FIFO and pending pop results
  class event_scoreboard;
    bit [PERIOD_W-1:0] period;
    bit [TICKS_W-1:0]  ticks;
    bit [TIME_W-1:0]   last_t;
    bit                stable_lvl [NUM_SW];
    bit                cand_lvl   [NUM_SW];
    bit [TICKS_W-1:0]  cand_cnt   [NUM_SW];
    bit [EVT_W-1:0]    store      [QDEPTH];
    int unsigned       rd_ptr, wr_ptr, fill;
    evt_t              expected_q [$];
    int unsigned       errors, checked, requests, samples, inits, pops, dropped;

    function new();
      period = PERIOD_RST;
      ticks  = TICKS_RST;
      last_t = '0;
      for (int i = 0; i < NUM_SW; i++) begin
        stable_lvl[i] = 1'b1;
        cand_lvl[i]   = 1'b1;
        cand_cnt[i]   = '0;
      end
      rd_ptr = 0; wr_ptr = 0; fill = 0;
      errors = 0; checked = 0; requests = 0;
      samples = 0; inits = 0; pops = 0; dropped = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SAMPLE_PERIOD: period = data[PERIOD_W-1:0];
        CFG_DEBOUNCE:      ticks  = data[TICKS_W-1:0];
        default: ;
      endcase
    endfunction

    // Drop the push when the FIFO already holds QDEPTH events
    function void push(bit src, bit lvl);
      if (fill >= QDEPTH) begin
        dropped++;
        return;
      end
      store[wr_ptr] = {src, lvl};
      wr_ptr = (wr_ptr + 1) % QDEPTH;
      fill++;
    endfunction

    function void sample(int idx, bit raw);
      if (raw != cand_lvl[idx]) begin
        cand_lvl[idx] = raw;
        cand_cnt[idx] = TICKS_W'(1);
        return;
      end
      if (cand_cnt[idx] < ticks) cand_cnt[idx]++;
      if (cand_cnt[idx] >= ticks && stable_lvl[idx] != cand_lvl[idx]) begin
        stable_lvl[idx] = cand_lvl[idx];
        push(bit'(idx), stable_lvl[idx]);
      end
    endfunction

    function void note_request(req_t r);
      evt_t            e;
      bit [TIME_W-1:0] elapsed;
      bit [EVT_W-1:0]  ent;
      requests++;
      case (r.mode)
        MODE_INIT: begin
          inits++;
          stable_lvl[0] = r.button_level;
          cand_lvl[0]   = r.button_level;
          cand_cnt[0]   = '0;
          stable_lvl[1] = r.sw2_level;
          cand_lvl[1]   = r.sw2_level;
          cand_cnt[1]   = '0;
          last_t = r.now_ms;
          rd_ptr = 0; wr_ptr = 0; fill = 0;
        end
        MODE_TICK: begin
          // Sample only once the wrapped time difference reaches the period
          elapsed = r.now_ms - last_t;
          if (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period}) begin
            samples++;
            last_t = r.now_ms;
            sample(0, r.button_level);
            sample(1, r.sw2_level);
          end
        end
        MODE_POP: begin
          pops++;
          e = '0;
          if (fill != 0) begin
            ent = store[rd_ptr];
            e.event_valid   = 1'b1;
            e.event_source  = ent[1];
            e.event_level   = ent[0];
            e.event_pressed = ~ent[0];
            rd_ptr = (rd_ptr + 1) % QDEPTH;
            fill--;
          end
          expected_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void mismatch(string field, logic want, logic got);
      errors++;
      $display("%0t: %s mismatch, expected %b, actual %b", $time, field, want, got);
    endfunction

    function void check_event(evt_t got);
      evt_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result transfer with none pending, expected none, actual %b",
                 $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.event_valid !== want.event_valid)
        mismatch("event_valid", want.event_valid, got.event_valid);
      if (got.event_source !== want.event_source)
        mismatch("event_source", want.event_source, got.event_source);
      if (got.event_level !== want.event_level)
        mismatch("event_level", want.event_level, got.event_level);
      if (got.event_pressed !== want.event_pressed)
        mismatch("event_pressed", want.event_pressed, got.event_pressed);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req       = '0;
  logic                  evt_valid;
  logic                  evt_stall = 1'b0;
  evt_t                  evt;

  event_scoreboard sb = new();

  bit              hold_request = 1'b0;
  bit [TIME_W-1:0] t_now;
  bit              lvl_b, lvl_s;
  int              idle_cycles = 0;
  int              settings_run = 1;

  dual_switch_debouncer_event_queue_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && evt_valid && !evt_stall) sb.check_event(evt);
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (req_valid && !req_stall) || (evt_valid && !evt_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stall pattern, with long hold-offs on request
  initial begin : receiver
    int seg_left;
    int style;
    int hold_left;
    bit stall_now;
    seg_left  = 0;
    style     = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = $urandom_range(250, 400);
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else begin
        if (seg_left == 0) begin
          style    = $urandom_range(0, 9);
          seg_left = $urandom_range(10, 120);
          if (style == 9) hold_left = $urandom_range(60, 150);
        end
        seg_left--;
        case (style)
          0, 1, 2: stall_now = 1'b0;
          3, 4, 5: stall_now = ($urandom_range(0, 4) == 0);
          default: stall_now = ($urandom_range(0, 9) < 7);
        endcase
      end
      evt_stall <= stall_now;
    end
  end

  // Offer one request and hold it until the transfer
  task automatic send_req(input req_t r);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic drive_item(input logic [1:0] mode, input logic [TIME_W-1:0] now,
                            input logic b, input logic s);
    req_t r;
    r.mode         = mode;
    r.now_ms       = now;
    r.button_level = b;
    r.sw2_level    = s;
    send_req(r);
  endtask

  // Drain all pending results, then write every register
  task automatic reconfigure(input logic [PERIOD_W-1:0] period,
                             input logic [TICKS_W-1:0] ticks);
    logic [CFG_IDX_W-1:0]  idx_list  [4];
    logic [CFG_DATA_W-1:0] data_list [4];
    idx_list[0]  = CFG_UNUSED_A;
    data_list[0] = CFG_DATA_W'($urandom);
    idx_list[1]  = CFG_SAMPLE_PERIOD;
    data_list[1] = period;
    idx_list[2]  = CFG_UNUSED_B;
    data_list[2] = CFG_DATA_W'($urandom);
    idx_list[3]  = CFG_DEBOUNCE;
    data_list[3] = {12'($urandom), ticks};
    req_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= data_list[i];
      @(posedge clk);
      sb.write_reg(idx_list[i], data_list[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_run++;
    @(negedge clk);
  endtask

  // Random requests: mostly well-paced ticks with held levels, plus pops and noise
  task automatic run_random(input int n, input int pop_pct);
    int              counted;
    int              roll;
    int              burst_left;
    bit [TIME_W-1:0] step;
    req_t            r;
    counted    = 0;
    burst_left = $urandom_range(1, 40);
    while (counted < n) begin
      if (counted == 40) hold_request = 1'b1;
      roll = $urandom_range(0, 99);
      r = '0;
      if (roll < 3) begin
        if ($urandom_range(0, 1) == 1) t_now = $urandom;
        lvl_b = 1'($urandom_range(0, 1));
        lvl_s = 1'($urandom_range(0, 1));
        r.mode = MODE_INIT;
      end else if (roll < 5) begin
        r.mode = MODE_UNUSED;
        r.now_ms = $urandom;
        r.button_level = 1'($urandom_range(0, 1));
        r.sw2_level = 1'($urandom_range(0, 1));
      end else if (roll < 5 + pop_pct) begin
        r.mode = MODE_POP;
        r.button_level = 1'($urandom_range(0, 1));
        r.sw2_level = 1'($urandom_range(0, 1));
      end else begin
        // Short steps may fall below the period; the rest sample
        if (roll < 17 + pop_pct) step = $urandom_range(0, sb.period);
        else step = sb.period + $urandom_range(0, 3);
        if ($urandom_range(0, 49) == 0) t_now = $urandom;
        else t_now = t_now + step;
        // Level runs scale with the debounce length, so both settle and bounce
        if ($urandom_range(0, 2 * sb.ticks + 2) == 0) lvl_b = ~lvl_b;
        if ($urandom_range(0, 2 * sb.ticks + 2) == 0) lvl_s = ~lvl_s;
        r.mode = MODE_TICK;
      end
      if (r.mode == MODE_INIT || r.mode == MODE_TICK) begin
        r.now_ms       = t_now;
        r.button_level = lvl_b;
        r.sw2_level    = lvl_s;
      end
      if (r.mode == MODE_POP) r.now_ms = $urandom;
      send_req(r);
      if (r.mode != MODE_UNUSED) counted++;
      // Burst pacing: gap after each burst
      if (burst_left == 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  initial begin : stimulus
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: default setting, debounce to both pressed, wrap of time
    drive_item(MODE_POP,    32'h0000_0000, 1'b0, 1'b0);
    drive_item(MODE_INIT,   32'h0000_0000, 1'b1, 1'b1);
    drive_item(MODE_TICK,   32'h0000_0005, 1'b0, 1'b0);
    drive_item(MODE_TICK,   32'h0000_000A, 1'b0, 1'b0);
    drive_item(MODE_TICK,   32'h0000_0014, 1'b0, 1'b0);
    drive_item(MODE_TICK,   32'h0000_001E, 1'b0, 1'b0);
    drive_item(MODE_POP,    32'h0000_0000, 1'b0, 1'b0);
    drive_item(MODE_POP,    32'h0000_0000, 1'b0, 1'b0);
    drive_item(MODE_POP,    32'h0000_0000, 1'b0, 1'b0);
    drive_item(MODE_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1);
    drive_item(MODE_INIT,   32'hFFFF_FFF0, 1'b0, 1'b1);
    drive_item(MODE_TICK,   32'hFFFF_FFFF, 1'b1, 1'b0);
    drive_item(MODE_TICK,   32'h0000_0009, 1'b1, 1'b0);
    drive_item(MODE_TICK,   32'h0000_0013, 1'b1, 1'b0);
    drive_item(MODE_POP,    32'h0000_0000, 1'b0, 1'b0);

    // Directed: zero period and zero debounce, overfill the queue, then drain it
    reconfigure('0, '0);
    drive_item(MODE_INIT, 32'hFFFF_FFFF, 1'b1, 1'b1);
    for (int i = 0; i < 5; i++) begin
      drive_item(MODE_TICK, 32'hFFFF_FFFF, i[0], i[0]);
      drive_item(MODE_TICK, 32'hFFFF_FFFF, i[0], i[0]);
    end
    for (int i = 0; i < QDEPTH + 1; i++) drive_item(MODE_POP, 32'h0, 1'b0, 1'b0);

    // Random phases over several settings, the extremes among them
    t_now = $urandom;
    lvl_b = 1'b1;
    lvl_s = 1'b1;
    reconfigure(PERIOD_RST, TICKS_RST);
    run_random(PHASE_ITEMS, 25);
    reconfigure(16'd1, 4'd1);
    run_random(PHASE_ITEMS, 8);
    reconfigure(16'hFFFF, 4'hF);
    run_random(PHASE_ITEMS, 20);
    reconfigure(PERIOD_W'($urandom_range(2, 200)), TICKS_W'($urandom_range(2, 14)));
    run_random(PHASE_ITEMS, 15);
    reconfigure('0, '0);
    run_random(PHASE_ITEMS, 30);

    // Drain and finish
    req_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (2 * DRAIN_CYCLES) @(negedge clk);
    $display("Ran %0d requests under %0d register settings: %0d samples, %0d inits, %0d pops.",
             sb.requests, settings_run, sb.samples, sb.inits, sb.pops);
    $display("Checked %0d result transfers; %0d pushes fell on a full queue.",
             sb.checked, sb.dropped);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
